// ===== design/rect_morton_index_convert_defines.svh =====
// Assertion macros for the Morton index converter checker.
// Included by rmic_checker.sv; no other dependencies.
`ifndef RECT_MORTON_INDEX_CONVERT_DEFINES_SVH
`define RECT_MORTON_INDEX_CONVERT_DEFINES_SVH

// Same-cycle implication check.
`define RMIC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check.
`define RMIC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rmic_pkg.sv =====
// Shared types and constants for the Morton index converter.
// No dependencies; used by every module of the block.
package rmic_pkg;

   localparam int COORD_W  = 10;
   localparam int INDEX_W  = 30;
   localparam int DOMAIN_W = 11;
   localparam int MAX_DIMS = 3;
   localparam int DIM_W    = 2;
   localparam int BOX_W    = 11;
   localparam int EXP_W    = 4;
   localparam int PROD_W   = 2 * BOX_W;
   localparam int POP_W    = PROD_W + BOX_W - 1;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [DIM_W-1:0] DIM_X = 2'd0;
   localparam logic [DIM_W-1:0] DIM_Y = 2'd1;
   localparam logic [DIM_W-1:0] DIM_Z = 2'd2;

   localparam logic [DIM_W-1:0] REG_DOMAIN_X = 2'd0;
   localparam logic [DIM_W-1:0] REG_DOMAIN_Y = 2'd1;
   localparam logic [DIM_W-1:0] REG_DOMAIN_Z = 2'd2;

   localparam logic OP_TO_INDEX = 1'b0;
   localparam logic OP_TO_COORD = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [COORD_W-1:0] coord_z;
      logic [INDEX_W-1:0] index_in;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] result_index;
      logic [COORD_W-1:0] result_x;
      logic [COORD_W-1:0] result_y;
      logic [COORD_W-1:0] result_z;
      logic               out_of_range;
   } rsp_type;

   typedef struct packed {
      logic             found;
      logic [EXP_W-1:0] exp;
      logic [DIM_W-1:0] dim;
   } best_type;

   typedef struct packed {
      logic             load;
      logic             apply;
      logic [DIM_W-1:0] sel_dim;
      logic [EXP_W-1:0] exp;
      logic             upper;
      logic             op;
   } cell_cmd_type;

   typedef struct packed {
      logic [BOX_W-1:0] box;
      logic [BOX_W-1:0] pos;
      logic             upper;
   } cell_stat_type;

   typedef logic [MAX_DIMS-1:0][BOX_W-1:0] side_vec_type;

endpackage

// ===== design/rect_morton_index_convert.sv =====
// Channel  | Ports                                   | Beat
// request  | start, busy, req_data                   | start && !busy
// response | rsp_strobe, rsp_data                    | rsp_strobe, one cycle
// config   | psel penable pwrite paddr pwdata prdata | psel && penable && pwrite
//
// A conversion goes from ST_IDLE to ST_PICK and then takes S bisection steps, S at
// most about 3 * SIDE_BITS; each step passes ST_PICK (split choice and product) and
// then ST_APPLY (update). Out-of-domain requests end in the first ST_PICK.
// Reset is synchronous; domain registers reset to 1. busy stays high from the
// accepted beat until the result strobe; results cannot be held off.
// Top level of the Morton index converter; depends on rmic_pkg, rmic_cell, rmic_csr.
module rect_morton_index_convert
   import rmic_pkg::*;
#(
   parameter int NUM_DIMS  = 3,
   parameter int SIDE_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_strobe,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PICK  = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic                op_ff, op_in;
   logic                bad_ff, bad_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic [DIM_W-1:0]    dim_ff, dim_in;
   logic [EXP_W-1:0]    exp_ff, exp_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   side_vec_type        side;
   best_type            chain [MAX_DIMS+1];
   cell_stat_type       stat [MAX_DIMS];
   cell_cmd_type        cmd;
   logic [MAX_DIMS-1:0][BOX_W-1:0] coord;
   logic [BOX_W-1:0]    mul_a, mul_b;
   logic [POP_W-1:0]    pop;
   logic                accept, upper, start_bad;

   rmic_csr #(
      .NUM_DIMS  (NUM_DIMS),
      .SIDE_BITS (SIDE_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .side    (side)
   );

   assign accept   = start && !busy;
   assign busy     = (state_ff != ST_IDLE);
   assign chain[0] = '0;

   always_comb begin
      coord[0] = BOX_W'(req_data.coord_x);
      coord[1] = BOX_W'(req_data.coord_y);
      coord[2] = BOX_W'(req_data.coord_z);
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (d >= NUM_DIMS || req_data.operation == OP_TO_COORD) begin
            coord[d] = '0;
         end
      end
   end

   always_comb begin
      start_bad = 1'b0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (side[d] == '0 || coord[d] >= side[d]) begin
            start_bad = 1'b1;
         end
      end
   end

   for (genvar g = 0; g < MAX_DIMS; g++) begin : g_cell
      rmic_cell #(
         .DIM_INDEX (g)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .load_box  (side[g]),
         .load_pos  (coord[g]),
         .chain_in  (chain[g]),
         .chain_out (chain[g+1]),
         .stat      (stat[g])
      );
   end

   always_comb begin
      unique case (chain[MAX_DIMS].dim)
         DIM_X: begin
            mul_a = stat[1].box;
            mul_b = stat[2].box;
         end
         DIM_Y: begin
            mul_a = stat[0].box;
            mul_b = stat[2].box;
         end
         DIM_Z: begin
            mul_a = stat[0].box;
            mul_b = stat[1].box;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign pop = POP_W'(prod_ff) << exp_ff;

   always_comb begin
      upper = 1'b0;
      if (op_ff == OP_TO_COORD) begin
         upper = (POP_W'(idx_ff) >= pop);
      end else begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            if (dim_ff == DIM_W'(d)) begin
               upper = stat[d].upper;
            end
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      bad_in        = bad_ff;
      idx_in        = idx_ff;
      dim_in        = dim_ff;
      exp_in        = exp_ff;
      prod_in       = prod_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      cmd           = '0;
      cmd.op        = op_ff;
      cmd.sel_dim   = dim_ff;
      cmd.exp       = exp_ff;
      cmd.upper     = upper;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               op_in    = req_data.operation;
               bad_in   = start_bad;
               idx_in   = (req_data.operation == OP_TO_COORD) ? req_data.index_in : '0;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (bad_ff || !chain[MAX_DIMS].found) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '0;
               if (op_ff == OP_TO_COORD) begin
                  if (bad_ff || idx_ff != '0) begin
                     rsp_data_in.out_of_range = 1'b1;
                  end else begin
                     rsp_data_in.result_x = stat[0].pos[COORD_W-1:0];
                     rsp_data_in.result_y = stat[1].pos[COORD_W-1:0];
                     rsp_data_in.result_z = stat[2].pos[COORD_W-1:0];
                  end
               end else if (bad_ff) begin
                  rsp_data_in.out_of_range = 1'b1;
               end else begin
                  rsp_data_in.result_index = idx_ff;
               end
               state_in = ST_IDLE;
            end else begin
               dim_in   = chain[MAX_DIMS].dim;
               exp_in   = chain[MAX_DIMS].exp;
               prod_in  = mul_a * mul_b;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            if (upper) begin
               idx_in = (op_ff == OP_TO_COORD) ? idx_ff - pop[INDEX_W-1:0]
                                               : idx_ff + pop[INDEX_W-1:0];
            end
            state_in = ST_PICK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      bad_ff      <= bad_in;
      idx_ff      <= idx_in;
      dim_ff      <= dim_in;
      exp_ff      <= exp_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== design/rmic_cell.sv =====
// One dimension cell of the bisection chain: box side, position, split choice.
// Depends on rmic_pkg.
module rmic_cell
   import rmic_pkg::*;
#(
   parameter int DIM_INDEX = 0
) (
   input  logic             clock,
   input  cell_cmd_type     cmd,
   input  logic [BOX_W-1:0] load_box,
   input  logic [BOX_W-1:0] load_pos,
   input  best_type         chain_in,
   output best_type         chain_out,
   output cell_stat_type    stat
);

   logic [BOX_W-1:0] box_ff, box_in;
   logic [BOX_W-1:0] pos_ff, pos_in;
   logic [BOX_W-1:0] box_m1;
   logic [EXP_W-1:0] own_exp;
   logic             own_valid;
   logic [BOX_W-1:0] step;

   always_comb begin
      box_m1  = box_ff - BOX_W'(1);
      own_exp = '0;
      for (int b = 0; b < BOX_W; b++) begin
         if (box_m1[b]) begin
            own_exp = EXP_W'(b);
         end
      end
   end

   assign own_valid = (box_ff > BOX_W'(1));

   always_comb begin
      if (own_valid && (!chain_in.found || own_exp >= chain_in.exp)) begin
         chain_out.found = 1'b1;
         chain_out.exp   = own_exp;
         chain_out.dim   = DIM_W'(DIM_INDEX);
      end else begin
         chain_out = chain_in;
      end
   end

   assign stat.box   = box_ff;
   assign stat.pos   = pos_ff;
   assign stat.upper = (pos_ff >= (BOX_W'(1) << own_exp));

   assign step = BOX_W'(1) << cmd.exp;

   always_comb begin
      box_in = box_ff;
      pos_in = pos_ff;
      if (cmd.load) begin
         box_in = load_box;
         pos_in = load_pos;
      end else if (cmd.apply && cmd.sel_dim == DIM_W'(DIM_INDEX)) begin
         if (cmd.upper) begin
            box_in = box_ff - step;
            pos_in = (cmd.op == OP_TO_COORD) ? pos_ff + step : pos_ff - step;
         end else begin
            box_in = step;
         end
      end
   end

   always_ff @(posedge clock) begin
      box_ff <= box_in;
      pos_ff <= pos_in;
   end

endmodule

// ===== design/rmic_csr.sv =====
// Domain size registers behind the APB-style port, with effective side output.
// Depends on rmic_pkg.
module rmic_csr
   import rmic_pkg::*;
#(
   parameter int NUM_DIMS  = 3,
   parameter int SIDE_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output side_vec_type      side
);

   localparam int unsigned SideCap = 32'd1 << SIDE_BITS;

   logic [MAX_DIMS-1:0][DOMAIN_W-1:0] domain_ff, domain_in;
   logic [DIM_W-1:0]                  reg_sel;
   logic                              wr_en;

   assign pready  = 1'b1;
   assign reg_sel = paddr[ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      domain_in = domain_ff;
      prdata    = '0;
      unique case (reg_sel)
         REG_DOMAIN_X: begin
            prdata = DATA_W'(domain_ff[0]);
            if (wr_en) domain_in[0] = pwdata[DOMAIN_W-1:0];
         end
         REG_DOMAIN_Y: begin
            prdata = DATA_W'(domain_ff[1]);
            if (wr_en) domain_in[1] = pwdata[DOMAIN_W-1:0];
         end
         REG_DOMAIN_Z: begin
            prdata = DATA_W'(domain_ff[2]);
            if (wr_en) domain_in[2] = pwdata[DOMAIN_W-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            domain_ff[d] <= DOMAIN_W'(1);
         end
      end else begin
         domain_ff <= domain_in;
      end
   end

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (d >= NUM_DIMS) begin
            side[d] = BOX_W'(1);
         end else if (32'(domain_ff[d]) > SideCap) begin
            side[d] = BOX_W'(SideCap);
         end else begin
            side[d] = BOX_W'(domain_ff[d]);
         end
      end
   end

endmodule

// ===== design/rmic_checker.sv =====
// Port-level checker for the Morton index converter, bound to the top level.
// Depends on rmic_pkg and rect_morton_index_convert_defines.svh.
`include "rect_morton_index_convert_defines.svh"

module rmic_checker
   import rmic_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   `RMIC_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy, "result beat while busy")
   `RMIC_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted beat did not raise busy")
   `RMIC_ASSERT_NEXT(a_no_early_rsp, clock, reset, start && !busy, !rsp_strobe, "result one cycle after accept")
   `RMIC_ASSERT_NOW(a_fall_strobe, clock, reset, $fell(busy), rsp_strobe, "busy dropped without result beat")
   `RMIC_ASSERT_NOW(a_oor_zero, clock, reset, rsp_strobe && rsp_data.out_of_range, rsp_data.result_index == '0 && rsp_data.result_x == '0 && rsp_data.result_y == '0 && rsp_data.result_z == '0, "flagged result carries data")

endmodule

bind rect_morton_index_convert rmic_checker u_rmic_checker (.*);
